// File: hw/rtl/pmo_pkg.sv
// Shared types, constants and arithmetic helpers for the polyline miter offset block.
`default_nettype none
package pmo_pkg;

    localparam int COORD_W = 32;
    localparam int DELTA_W = 33;
    localparam int WIDTH_W = 31;
    localparam int IN_DATA_W = 96;
    localparam int OUT_DATA_W = 160;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;
    localparam int QCW = 3;
    localparam int DVD_W = 64;
    localparam int DVS_W = 35;
    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = 31'd65536;

    typedef enum logic [1:0] {
        JOB_LONE,
        JOB_END,
        JOB_INNER
    } job_kind_t;

    // One unit of work for the back end
    typedef struct packed {
        job_kind_t                   kind;
        logic signed [COORD_W-1:0]   px;
        logic signed [COORD_W-1:0]   py;
        logic signed [COORD_W-1:0]   pz;
        logic signed [DELTA_W-1:0]   d1x;
        logic signed [DELTA_W-1:0]   d1y;
        logic signed [DELTA_W-1:0]   d2x;
        logic signed [DELTA_W-1:0]   d2y;
        logic                        run_end;
    } job_t;

    // Queue status seen by the front end
    typedef struct packed {
        logic room;
        logic valid;
    } q_stat_t;

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    // Clamp a wide value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Divide by 2^31, rounding half away from zero
    function automatic logic signed [34:0] rnd_q31(input logic signed [65:0] p);
        logic [65:0] m;
        logic [65:0] q;
        logic signed [34:0] qs;
        m = p[65] ? 66'(-p) : 66'(p);
        q = (m + (66'd1 << 30)) >> 31;
        qs = $signed(q[34:0]);
        return p[65] ? -qs : qs;
    endfunction

    // Divide by 2^30, rounding half away from zero
    function automatic logic signed [34:0] rnd_q30(input logic signed [65:0] p);
        logic [65:0] m;
        logic [65:0] q;
        logic signed [34:0] qs;
        m = p[65] ? 66'(-p) : 66'(p);
        q = (m + (66'd1 << 29)) >> 30;
        qs = $signed(q[34:0]);
        return p[65] ? -qs : qs;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pmo_queue.sv
// Short job queue between the front end and the back end.
`default_nettype none
module pmo_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  pmo_pkg::job_t      push_job,
    input  wire logic          pop,
    output pmo_pkg::job_t      head_job,
    output pmo_pkg::q_stat_t   stat
);
    import pmo_pkg::*;

    job_t             mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;

    assign head_job   = mem[rd_ptr_reg];
    assign stat.valid = (count_reg != '0);
    // room for two more jobs
    assign stat.room  = (count_reg <= QCW'(QDEPTH - 2));

    // write entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/pmo_front.sv
// Front end: accepts vertices, tracks the held vertices and issues jobs.
`default_nettype none
module pmo_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [95:0]   s_tdata,  // vx, vy, vz
    input  wire logic          s_tlast,  // final_vertex
    input  pmo_pkg::q_stat_t   q_stat,
    output logic               q_push,
    output pmo_pkg::job_t      q_job
);
    import pmo_pkg::*;

    logic [1:0]                seen_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic signed [COORD_W-1:0] older_x_reg, older_y_reg;
    job_t                      pend_reg;
    logic                      pend_valid_reg;

    logic signed [COORD_W-1:0] cx, cy, cz;
    logic signed [DELTA_W-1:0] dcx, dcy;
    logic                      accept;
    logic                      push1;
    job_t                      job1, job2;

    assign cx = $signed(s_tdata[31:0]);
    assign cy = $signed(s_tdata[63:32]);
    assign cz = $signed(s_tdata[95:64]);
    assign dcx = DELTA_W'(cx) - DELTA_W'(prev_x_reg);
    assign dcy = DELTA_W'(cy) - DELTA_W'(prev_y_reg);

    assign s_tready = q_stat.room && !pend_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // classify the incoming vertex
    always_comb begin
        job1 = '0;
        push1 = 1'b0;
        case (seen_reg)
            2'd0: begin
                job1.kind = JOB_LONE;
                job1.px = cx;
                job1.py = cy;
                job1.pz = cz;
                job1.run_end = 1'b1;
                push1 = s_tlast;
            end
            2'd1: begin
                job1.kind = JOB_END;
                job1.px = prev_x_reg;
                job1.py = prev_y_reg;
                job1.pz = prev_z_reg;
                job1.d1x = dcx;
                job1.d1y = dcy;
                push1 = 1'b1;
            end
            default: begin
                job1.kind = JOB_INNER;
                job1.px = prev_x_reg;
                job1.py = prev_y_reg;
                job1.pz = prev_z_reg;
                job1.d1x = DELTA_W'(prev_x_reg) - DELTA_W'(older_x_reg);
                job1.d1y = DELTA_W'(prev_y_reg) - DELTA_W'(older_y_reg);
                job1.d2x = dcx;
                job1.d2y = dcy;
                push1 = 1'b1;
            end
        endcase
        job2 = '0;
        job2.kind = JOB_END;
        job2.px = cx;
        job2.py = cy;
        job2.pz = cz;
        job2.d1x = dcx;
        job2.d1y = dcy;
        job2.run_end = 1'b1;
    end

    assign q_push = (accept && push1) || pend_valid_reg;
    assign q_job  = pend_valid_reg ? pend_reg : job1;

    // hold vertex history and the second job of a final vertex
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg       <= 2'd0;
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= 1'b0;
            if (accept) begin
                if (s_tlast) begin
                    seen_reg <= 2'd0;
                    if (seen_reg != 2'd0) begin
                        pend_reg       <= job2;
                        pend_valid_reg <= 1'b1;
                    end
                end else begin
                    older_x_reg <= prev_x_reg;
                    older_y_reg <= prev_y_reg;
                    prev_x_reg  <= cx;
                    prev_y_reg  <= cy;
                    prev_z_reg  <= cz;
                    seen_reg    <= (seen_reg == 2'd0) ? 2'd1 : 2'd2;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/pmo_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module pmo_div (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic          short_mode,
    input  wire logic [63:0]   dividend,
    input  wire logic [34:0]   divisor,
    output logic               done,
    output logic [63:0]        quotient
);
    import pmo_pkg::*;

    logic [6:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  quo_reg;

    logic [DVS_W:0]    trial;
    logic              ge;

    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    // shift in one dividend bit and subtract where it fits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                dvs_reg  <= divisor;
                quo_reg  <= '0;
                if (short_mode) begin
                    cnt_reg <= 7'd32;
                    rem_reg <= {3'b0, dividend[63:32]};
                    dvd_reg <= {dividend[31:0], 32'b0};
                end else begin
                    cnt_reg <= 7'd64;
                    rem_reg <= '0;
                    dvd_reg <= dividend;
                end
            end else if (busy_reg) begin
                rem_reg <= ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                quo_reg <= {quo_reg[DVD_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/pmo_back.sv
// Back end: runs offset jobs through a shared multiplier, square root and divider.
`default_nettype none
module pmo_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [30:0]   cfg_wr_data,
    input  wire logic          job_valid,
    input  pmo_pkg::job_t      job,
    output logic               job_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [159:0]       m_tdata,  // first_x, first_y, second_x, second_y, point_z
    output logic               m_tlast,  // run_end
    output logic               m_tuser   // degenerate
);
    import pmo_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_NORM, S_SQX, S_SQY, S_SQSUM, S_SQRT, S_DIVX, S_WAITX,
        S_DIVY, S_WAITY, S_UDONE, S_ENDA, S_ENDB, S_ENDC, S_ENDOUT,
        S_DOT1, S_DOT2, S_DSUM, S_DEN, S_DCHK, S_MXM, S_MXS, S_MXW,
        S_MYM, S_MYS, S_MYW, S_INOUT, S_OUT
    } state_t;

    state_t                    state_reg;
    logic [WIDTH_W-1:0]        lw_reg;
    job_t                      job_reg;
    logic [31:0]               ax_reg, ay_reg;
    logic                      sgnx_reg, sgny_reg;
    logic                      ud_sel_reg, ud_zero_reg, zero1_reg;
    logic signed [65:0]        prod_reg;
    logic [63:0]               sq_reg;
    logic [63:0]               sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [31:0]               len_reg;
    logic [31:0]               qx_reg, qy_reg;
    logic signed [31:0]        e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [34:0]        a_reg, b_reg;
    logic signed [65:0]        dot_reg;
    logic signed [32:0]        sx_reg, sy_reg;
    logic signed [35:0]        den_reg;
    logic                      psgn_reg;
    logic signed [65:0]        mx_reg, my_reg;
    logic signed [31:0]        res_fx_reg, res_fy_reg, res_sx_reg, res_sy_reg;
    logic                      res_deg_reg;
    logic                      m_tvalid_reg;
    logic [159:0]              m_tdata_reg;
    logic                      m_tlast_reg, m_tuser_reg;

    logic signed [32:0]        mul_a, mul_b;
    logic signed [65:0]        prod;
    logic [63:0]               prod_mag;
    logic [63:0]               sq_t;
    logic                      sq_ge;
    logic [31:0]               mx_cur;
    logic                      div_start, div_short, div_done;
    logic [63:0]               div_dvd, div_q;
    logic [34:0]               div_dvs;
    logic signed [31:0]        ex_cur, ey_cur;
    logic signed [65:0]        q_signed;
    logic                      slot_free;

    localparam logic signed [35:0] ONE30 = 36'sd1073741824;

    function automatic logic [31:0] mag_d(input logic signed [32:0] d);
        logic [32:0] m;
        m = d[32] ? 33'(-d) : 33'(d);
        return m[31:0];
    endfunction

    // saturation limit along a direction, vertex itself for a zero component
    function automatic logic signed [31:0] toward(input logic signed [31:0] p,
                                                  input logic signed [31:0] e,
                                                  input logic plus);
        logic signed [31:0] r;
        if (e == 32'sd0) begin
            r = p;
        end else if ((!e[31]) == plus) begin
            r = 32'sh7FFFFFFF;
        end else begin
            r = 32'sh80000000;
        end
        return r;
    endfunction

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQX: begin
                mul_a = $signed({2'b0, ax_reg[30:0]});
                mul_b = $signed({2'b0, ax_reg[30:0]});
            end
            S_SQY: begin
                mul_a = $signed({2'b0, ay_reg[30:0]});
                mul_b = $signed({2'b0, ay_reg[30:0]});
            end
            S_ENDA: begin
                mul_a = $signed({2'b0, lw_reg});
                mul_b = 33'(e1y_reg);
            end
            S_ENDB: begin
                mul_a = $signed({2'b0, lw_reg});
                mul_b = 33'(e1x_reg);
            end
            S_DOT1: begin
                mul_a = 33'(e1x_reg);
                mul_b = 33'(e2x_reg);
            end
            S_DOT2: begin
                mul_a = 33'(e1y_reg);
                mul_b = 33'(e2y_reg);
            end
            S_MXM: begin
                mul_a = $signed({2'b0, lw_reg});
                mul_b = sx_reg;
            end
            S_MYM: begin
                mul_a = $signed({2'b0, lw_reg});
                mul_b = sy_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_mag = prod_reg[65] ? 64'(-prod_reg) : 64'(prod_reg);
    assign sq_t     = sq_res_reg + sq_bit_reg;
    assign sq_ge    = (sq_v_reg >= sq_t);
    assign mx_cur   = (ax_reg > ay_reg) ? ax_reg : ay_reg;
    assign ex_cur   = sgnx_reg ? -$signed(qx_reg) : $signed(qx_reg);
    assign ey_cur   = sgny_reg ? -$signed(qy_reg) : $signed(qy_reg);
    assign q_signed = psgn_reg ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_short = 1'b1;
        div_dvd   = '0;
        div_dvs   = '0;
        case (state_reg)
            S_DIVX: begin
                div_start = 1'b1;
                div_dvd   = ({32'b0, ax_reg} << 30) + {33'b0, sq_res_reg[31:1]};
                div_dvs   = {3'b0, sq_res_reg[31:0]};
            end
            S_DIVY: begin
                div_start = 1'b1;
                div_dvd   = ({32'b0, ay_reg} << 30) + {33'b0, len_reg[31:1]};
                div_dvs   = {3'b0, len_reg};
            end
            S_MXS, S_MYS: begin
                div_start = 1'b1;
                div_short = 1'b0;
                div_dvd   = prod_mag + {30'b0, den_reg[33:0]};
                div_dvs   = {den_reg[33:0], 1'b0};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    pmo_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .short_mode (div_short),
        .dividend   (div_dvd),
        .divisor    (div_dvs),
        .done       (div_done),
        .quotient   (div_q)
    );

    assign slot_free = !m_tvalid_reg || m_tready;
    assign job_pop   = (state_reg == S_IDLE) && job_valid;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = m_tuser_reg;

    // sequence one job and hold the output item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            lw_reg       <= LINE_WIDTH_RST;
        end else begin
            if (cfg_wr_en) begin
                lw_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        job_reg     <= job;
                        ax_reg      <= mag_d(job.d1x);
                        ay_reg      <= mag_d(job.d1y);
                        sgnx_reg    <= job.d1x[32];
                        sgny_reg    <= job.d1y[32];
                        ud_sel_reg  <= 1'b0;
                        ud_zero_reg <= 1'b0;
                        if (job.kind == JOB_LONE) begin
                            res_fx_reg  <= job.px;
                            res_fy_reg  <= job.py;
                            res_sx_reg  <= job.px;
                            res_sy_reg  <= job.py;
                            res_deg_reg <= 1'b0;
                            state_reg   <= S_OUT;
                        end else begin
                            state_reg <= S_NORM;
                        end
                    end
                end
                // bring the larger magnitude into [2^30, 2^31)
                S_NORM: begin
                    if (mx_cur == 32'd0) begin
                        ud_zero_reg <= 1'b1;
                        state_reg   <= S_UDONE;
                    end else if (mx_cur[31]) begin
                        ax_reg <= ax_reg >> 1;
                        ay_reg <= ay_reg >> 1;
                    end else if (!mx_cur[30]) begin
                        ax_reg <= ax_reg << 1;
                        ay_reg <= ay_reg << 1;
                    end else begin
                        state_reg <= S_SQX;
                    end
                end
                S_SQX: begin
                    prod_reg  <= prod;
                    state_reg <= S_SQY;
                end
                S_SQY: begin
                    sq_reg    <= prod_reg[63:0];
                    prod_reg  <= prod;
                    state_reg <= S_SQSUM;
                end
                S_SQSUM: begin
                    sq_v_reg   <= sq_reg + prod_reg[63:0];
                    sq_res_reg <= '0;
                    sq_bit_reg <= 64'd1 << 62;
                    state_reg  <= S_SQRT;
                end
                // one result bit of the integer square root per cycle
                S_SQRT: begin
                    if (sq_ge) begin
                        sq_v_reg   <= sq_v_reg - sq_t;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg == 64'd1) begin
                        state_reg <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    len_reg   <= sq_res_reg[31:0];
                    state_reg <= S_WAITX;
                end
                S_WAITX: begin
                    if (div_done) begin
                        qx_reg    <= div_q[31:0];
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    state_reg <= S_WAITY;
                end
                S_WAITY: begin
                    if (div_done) begin
                        qy_reg    <= div_q[31:0];
                        state_reg <= S_UDONE;
                    end
                end
                // store the unit direction and pick the next step
                S_UDONE: begin
                    if (!ud_sel_reg) begin
                        e1x_reg   <= ex_cur;
                        e1y_reg   <= ey_cur;
                        zero1_reg <= ud_zero_reg;
                        if (job_reg.kind == JOB_INNER) begin
                            ax_reg      <= mag_d(job_reg.d2x);
                            ay_reg      <= mag_d(job_reg.d2y);
                            sgnx_reg    <= job_reg.d2x[32];
                            sgny_reg    <= job_reg.d2y[32];
                            ud_sel_reg  <= 1'b1;
                            ud_zero_reg <= 1'b0;
                            state_reg   <= S_NORM;
                        end else if (ud_zero_reg) begin
                            res_fx_reg  <= job_reg.px;
                            res_fy_reg  <= job_reg.py;
                            res_sx_reg  <= job_reg.px;
                            res_sy_reg  <= job_reg.py;
                            res_deg_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end else begin
                            state_reg <= S_ENDA;
                        end
                    end else begin
                        e2x_reg <= ex_cur;
                        e2y_reg <= ey_cur;
                        if (zero1_reg || ud_zero_reg) begin
                            res_fx_reg  <= job_reg.px;
                            res_fy_reg  <= job_reg.py;
                            res_sx_reg  <= job_reg.px;
                            res_sy_reg  <= job_reg.py;
                            res_deg_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end else begin
                            state_reg <= S_DOT1;
                        end
                    end
                end
                // perpendicular offset at an endpoint
                S_ENDA: begin
                    prod_reg  <= prod;
                    state_reg <= S_ENDB;
                end
                S_ENDB: begin
                    a_reg     <= rnd_q31(prod_reg);
                    prod_reg  <= prod;
                    state_reg <= S_ENDC;
                end
                S_ENDC: begin
                    b_reg     <= rnd_q31(prod_reg);
                    state_reg <= S_ENDOUT;
                end
                S_ENDOUT: begin
                    res_fx_reg  <= sat32(66'(job_reg.px) + 66'(a_reg));
                    res_fy_reg  <= sat32(66'(job_reg.py) - 66'(b_reg));
                    res_sx_reg  <= sat32(66'(job_reg.px) - 66'(a_reg));
                    res_sy_reg  <= sat32(66'(job_reg.py) + 66'(b_reg));
                    res_deg_reg <= 1'b0;
                    state_reg   <= S_OUT;
                end
                // miter at an inner vertex
                S_DOT1: begin
                    prod_reg  <= prod;
                    state_reg <= S_DOT2;
                end
                S_DOT2: begin
                    dot_reg   <= prod_reg;
                    prod_reg  <= prod;
                    state_reg <= S_DSUM;
                end
                S_DSUM: begin
                    dot_reg   <= dot_reg + prod_reg;
                    sx_reg    <= -(33'(e1y_reg) + 33'(e2y_reg));
                    sy_reg    <= 33'(e1x_reg) + 33'(e2x_reg);
                    state_reg <= S_DEN;
                end
                S_DEN: begin
                    den_reg   <= ONE30 + 36'(rnd_q30(dot_reg));
                    state_reg <= S_DCHK;
                end
                S_DCHK: begin
                    if (den_reg[35] || den_reg == 36'sd0) begin
                        res_fx_reg  <= toward(job_reg.px, e2x_reg, 1'b0);
                        res_fy_reg  <= toward(job_reg.py, e2y_reg, 1'b0);
                        res_sx_reg  <= toward(job_reg.px, e2x_reg, 1'b1);
                        res_sy_reg  <= toward(job_reg.py, e2y_reg, 1'b1);
                        res_deg_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end else begin
                        state_reg <= S_MXM;
                    end
                end
                S_MXM: begin
                    prod_reg  <= prod;
                    state_reg <= S_MXS;
                end
                S_MXS: begin
                    psgn_reg  <= prod_reg[65];
                    state_reg <= S_MXW;
                end
                S_MXW: begin
                    if (div_done) begin
                        mx_reg    <= q_signed;
                        state_reg <= S_MYM;
                    end
                end
                S_MYM: begin
                    prod_reg  <= prod;
                    state_reg <= S_MYS;
                end
                S_MYS: begin
                    psgn_reg  <= prod_reg[65];
                    state_reg <= S_MYW;
                end
                S_MYW: begin
                    if (div_done) begin
                        my_reg    <= q_signed;
                        state_reg <= S_INOUT;
                    end
                end
                S_INOUT: begin
                    res_fx_reg  <= sat32(66'(job_reg.px) - mx_reg);
                    res_fy_reg  <= sat32(66'(job_reg.py) - my_reg);
                    res_sx_reg  <= sat32(66'(job_reg.px) + mx_reg);
                    res_sy_reg  <= sat32(66'(job_reg.py) + my_reg);
                    res_deg_reg <= 1'b0;
                    state_reg   <= S_OUT;
                end
                // hand the item to the output register once it is free
                S_OUT: begin
                    if (slot_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {job_reg.pz, res_sy_reg, res_sx_reg,
                                         res_fy_reg, res_fx_reg};
                        m_tlast_reg  <= job_reg.run_end;
                        m_tuser_reg  <= res_deg_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/polyline_miter_offset_core.sv
// Top level of the polyline miter offset block.
// Usage:
//   s_* carries one polyline vertex per item (vx, vy, vz, tlast = final vertex).
//   m_* carries one offset point pair per item (first/second point, z,
//   tlast = last result of the polyline, tuser = degenerate).
//   cfg_wr_en/cfg_wr_data write line_width; write only while the block is idle.
// Results lag their vertex by one item; a non-lone final vertex yields two items.
// Timing: the front end takes a vertex while the job queue (four entries) has
//   room for two jobs and no second job of a final vertex waits. The back end
//   runs one job at a time on one multiplier, a square root that yields one
//   bit per cycle and a divider that yields one quotient bit per cycle. An end
//   job normalizes, takes a square root and runs two 32-bit divides; an inner
//   job does so for two unit directions and then runs two 64-bit divides.
//   Sustained rate is set by that divider and square root.
// Reset (aresetn low, synchronous) empties the queue, forgets held vertices
//   and sets line_width to 1.0. When m_tready is low the finished item waits
//   in the output register, the back end stops at its next result and the
//   queue fills until s_tready drops.
`default_nettype none
module polyline_miter_offset_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [30:0]   cfg_wr_data,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [95:0]   s_tdata,  // vx, vy, vz
    input  wire logic          s_tlast,  // final_vertex
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [159:0]       m_tdata,  // first_x, first_y, second_x, second_y, point_z
    output logic               m_tlast,  // run_end
    output logic               m_tuser   // degenerate
);
    import pmo_pkg::*;

    q_stat_t  q_stat;
    logic     q_push;
    logic     q_pop;
    job_t     q_in_job;
    job_t     q_head_job;

    pmo_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_job    (q_in_job)
    );

    pmo_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_in_job),
        .pop      (q_pop),
        .head_job (q_head_job),
        .stat     (q_stat)
    );

    pmo_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .job_valid   (q_stat.valid),
        .job         (q_head_job),
        .job_pop     (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule
`default_nettype wire
